// ===== hdl/mbrd_pkg.sv =====
package mbrd_pkg;

  typedef enum logic [2:0] {
    PH_SOF  = 3'b001,
    PH_DATA = 3'b010,
    PH_EOF  = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    REG_EXPECTED_SLAVE    = 2'd0,
    REG_EXPECTED_FUNCTION = 2'd1,
    REG_DEAD_TIME_LIMIT   = 2'd2
  } reg_index_t;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] SILENCE_MAX = 16'hFFFF;
  localparam logic [6:0] COUNT_SHORT = 7'd2;
  localparam logic [6:0] COUNT_LONG = 7'd4;
  localparam logic [6:0] FIRST_DATA_INDEX = 7'd3;

  typedef struct packed {
    logic [7:0]  expected_slave;
    logic [7:0]  expected_function;
    logic [15:0] dead_time_limit;
  } cfg_t;

  typedef struct packed {
    logic        frame_good;
    logic        crc_bad;
    logic [6:0]  payload_count;
    logic [15:0] value_short;
    logic [31:0] value_long;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/mbrd_engine.sv =====
module mbrd_engine #(
  parameter int MAX_COUNT = 100
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          action,
  input  logic [7:0]    rx_byte,
  input  mbrd_pkg::cfg_t cfg,
  output logic          res_valid,
  output mbrd_pkg::res_t res
);

  mbrd_pkg::phase_t phase, phase_next;
  logic [6:0]  byte_index, byte_index_next;
  logic [6:0]  end_index, end_index_next;
  logic [6:0]  count_field, count_field_next;
  logic [15:0] crc_running, crc_running_next;
  logic [15:0] crc_received, crc_received_next;
  logic [31:0] data_word, data_word_next;
  logic [15:0] silence_ticks, silence_ticks_next;

  mbrd_pkg::phase_t ph_e;
  logic [6:0]  idx_e, end_e, cnt_e;
  logic [15:0] crc_e, crcr_e;
  logic [31:0] data_e;
  logic        dead_restart;

  logic [7:0]  data_limit;
  logic [15:0] crc_abs, crcr_abs;
  logic [31:0] data_abs;
  logic        good;

  // A byte after too long a silence starts a fresh frame before it is looked at.
  assign dead_restart = !action && (silence_ticks >= cfg.dead_time_limit);

  always_comb begin
    if (dead_restart) begin
      ph_e   = mbrd_pkg::PH_SOF;
      idx_e  = '0;
      end_e  = '0;
      cnt_e  = '0;
      crc_e  = mbrd_pkg::CRC_INIT;
      crcr_e = '0;
      data_e = '0;
    end else begin
      ph_e   = phase;
      idx_e  = byte_index;
      end_e  = end_index;
      cnt_e  = count_field;
      crc_e  = crc_running;
      crcr_e = crc_received;
      data_e = data_word;
    end
  end

  // Routing of a byte after the header: data bytes feed the CRC and the data
  // shift register, then the two received CRC bytes arrive low byte first.
  always_comb begin
    data_limit = {1'b0, cnt_e} + 8'd2;
    crc_abs    = crc_e;
    crcr_abs   = crcr_e;
    data_abs   = data_e;
    if ({1'b0, idx_e} <= data_limit) begin
      crc_abs  = mbrd_pkg::crc_feed(crc_e, rx_byte);
      data_abs = {data_e[23:0], rx_byte};
    end else if ({1'b0, idx_e} == data_limit + 8'd1) begin
      crcr_abs = {8'h00, rx_byte};
    end else begin
      crcr_abs = crcr_e | {rx_byte, 8'h00};
    end
  end

  assign good = (crcr_abs == crc_abs) && (crc_abs != 16'h0000);

  always_comb begin
    phase_next        = phase;
    byte_index_next   = byte_index;
    end_index_next    = end_index;
    count_field_next  = count_field;
    crc_running_next  = crc_running;
    crc_received_next = crc_received;
    data_word_next    = data_word;
    silence_ticks_next = silence_ticks;
    res_valid         = 1'b0;
    res               = '0;

    if (action) begin
      if (silence_ticks != mbrd_pkg::SILENCE_MAX) begin
        silence_ticks_next = silence_ticks + 16'd1;
      end
    end else begin
      silence_ticks_next = '0;
      phase_next        = ph_e;
      byte_index_next   = idx_e;
      end_index_next    = end_e;
      count_field_next  = cnt_e;
      crc_running_next  = crc_e;
      crc_received_next = crcr_e;
      data_word_next    = data_e;

      unique case (ph_e)
        mbrd_pkg::PH_DATA: begin
          crc_running_next  = crc_abs;
          crc_received_next = crcr_abs;
          data_word_next    = data_abs;
          if (idx_e >= end_e) begin
            end_index_next = end_e + 7'd2;
            phase_next     = mbrd_pkg::PH_EOF;
          end
          byte_index_next = idx_e + 7'd1;
        end
        mbrd_pkg::PH_EOF: begin
          crc_running_next  = crc_abs;
          crc_received_next = crcr_abs;
          data_word_next    = data_abs;
          if (idx_e < end_e) begin
            byte_index_next = idx_e + 7'd1;
          end else begin
            if (idx_e == end_e) begin
              res_valid         = 1'b1;
              res.frame_good    = good;
              res.crc_bad       = !good;
              res.payload_count = cnt_e;
              res.value_short   = (good && cnt_e == mbrd_pkg::COUNT_SHORT) ?
                                  data_abs[15:0] : 16'h0000;
              res.value_long    = (good && cnt_e == mbrd_pkg::COUNT_LONG) ?
                                  data_abs : 32'h0000_0000;
            end
            phase_next        = mbrd_pkg::PH_SOF;
            byte_index_next   = '0;
            end_index_next    = '0;
            count_field_next  = '0;
            crc_running_next  = mbrd_pkg::CRC_INIT;
            crc_received_next = '0;
            data_word_next    = '0;
          end
        end
        default: begin
          if (idx_e == 7'd0 && rx_byte == cfg.expected_slave) begin
            crc_running_next = mbrd_pkg::crc_feed(crc_e, rx_byte);
            byte_index_next  = 7'd1;
          end else if (idx_e == 7'd1 && rx_byte == cfg.expected_function) begin
            crc_running_next = mbrd_pkg::crc_feed(crc_e, rx_byte);
            byte_index_next  = 7'd2;
          end else if (idx_e == 7'd2 && rx_byte < 8'(MAX_COUNT)) begin
            crc_running_next = mbrd_pkg::crc_feed(crc_e, rx_byte);
            count_field_next = rx_byte[6:0];
            end_index_next   = rx_byte[6:0] + 7'd2;
            phase_next       = mbrd_pkg::PH_DATA;
            byte_index_next  = mbrd_pkg::FIRST_DATA_INDEX;
          end else begin
            phase_next        = mbrd_pkg::PH_SOF;
            byte_index_next   = '0;
            end_index_next    = '0;
            count_field_next  = '0;
            crc_running_next  = mbrd_pkg::CRC_INIT;
            crc_received_next = '0;
            data_word_next    = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mbrd_pkg::PH_SOF;
      byte_index    <= '0;
      end_index     <= '0;
      count_field   <= '0;
      crc_running   <= mbrd_pkg::CRC_INIT;
      crc_received  <= '0;
      data_word     <= '0;
      silence_ticks <= '0;
    end else if (step) begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      end_index     <= end_index_next;
      count_field   <= count_field_next;
      crc_running   <= crc_running_next;
      crc_received  <= crc_received_next;
      data_word     <= data_word_next;
      silence_ticks <= silence_ticks_next;
    end
  end

  // A finished frame always leaves the engine looking for a new address.
  assert property (@(posedge clk) disable iff (rst)
    step && res_valid |=> phase == mbrd_pkg::PH_SOF && byte_index == 7'd0)
    else $error("framing not restarted after a result");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot({res.frame_good, res.crc_bad}))
    else $error("result is neither clearly good nor clearly bad");

  assert property (@(posedge clk) disable iff (rst)
    count_field < 7'(MAX_COUNT))
    else $error("byte count held beyond its limit");

  // With a zero byte count the index already sits one past the end here.
  assert property (@(posedge clk) disable iff (rst)
    phase == mbrd_pkg::PH_DATA |-> byte_index >= mbrd_pkg::FIRST_DATA_INDEX &&
                                   byte_index <= end_index + 7'd1)
    else $error("data index outside the frame");

  assert property (@(posedge clk) disable iff (rst)
    step && !action |=> silence_ticks == 16'd0)
    else $error("silence counter not cleared by a byte");

endmodule

// ===== hdl/modbus_rtu_response_deframer.sv =====
// Deframer for Modbus RTU read responses with a CRC-16 check.
// The input channel carries one word per received UART byte or timer tick:
// s_tuser says which (0 = byte in s_tdata, 1 = tick). Ticks count bus silence;
// a byte that arrives after dead_time_limit ticks starts framing afresh.
// A frame must carry the expected slave address and function code and a byte
// count below MAX_COUNT; a header mismatch drops the byte and restarts.
// Each complete frame produces one output word: the good and bad flags in
// m_tuser, and the byte count with the big-endian 16-bit or 32-bit data value
// in m_tdata. Other words produce nothing on the output.
// An input word is registered, processed by the frame engine's combinational
// logic and its result registered. One word is accepted per cycle while the
// output is not stalled, and the byte-wide CRC update of the engine sits
// between the input and output registers. When the receiver holds m_tready
// low with a result waiting, the input register is kept and s_tready falls
// until the result is taken. Reset clears the framing state, the silence
// counter and the registers to slave 0, function 0 and a dead time of two
// ticks. The user must see that configuration is written through cfg_we,
// cfg_addr and cfg_wdata only while idle; the block does not enforce it.
module modbus_rtu_response_deframer #(
  parameter int MAX_COUNT = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [6:0] payload_count, [22:7] value_short,
                                 // [54:23] value_long, [55] zero
  output logic [1:0]  m_tuser,   // [0] frame_good, [1] crc_bad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  mbrd_pkg::cfg_t cfg;
  mbrd_pkg::res_t res, out_res;

  logic       in_valid;
  logic       in_action;
  logic [7:0] in_byte;
  logic       advance;
  logic       res_valid;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_slave    <= 8'h00;
      cfg.expected_function <= 8'h00;
      cfg.dead_time_limit   <= 16'd2;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mbrd_pkg::REG_EXPECTED_SLAVE:    cfg.expected_slave    <= cfg_wdata[7:0];
        mbrd_pkg::REG_EXPECTED_FUNCTION: cfg.expected_function <= cfg_wdata[7:0];
        mbrd_pkg::REG_DEAD_TIME_LIMIT:   cfg.dead_time_limit   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser[0];
      in_byte   <= s_tdata;
    end
  end

  mbrd_engine #(
    .MAX_COUNT(MAX_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .action    (in_action),
    .rx_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res.value_long, out_res.value_short, out_res.payload_count};
  assign m_tuser = {out_res.crc_bad, out_res.frame_good};

endmodule

// ===== tb/tb_modbus_rtu_response_deframer.sv =====
module tb_modbus_rtu_response_deframer;

  localparam int FRAME_COUNT_LIMIT = 100;
  localparam int FULL_FRAME = 1000;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic       tick;
    logic [7:0] data;
  } bus_word_t;

  typedef enum {FK_GOOD, FK_BAD_CRC, FK_ZERO_CRC} frame_kind_t;

  typedef enum {
    NZ_BYTES, NZ_TICKS, NZ_BAD_SLAVE, NZ_BAD_FUNCTION, NZ_BIG_COUNT, NZ_CUT_FRAME
  } noise_kind_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [0:0]  s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = 2'd0;
  logic [15:0] cfg_wdata = 16'h0000;

  modbus_rtu_response_deframer #(
    .MAX_COUNT(FRAME_COUNT_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Link settings as the block should hold them.
  logic [7:0]  exp_slave = 8'h00;
  logic [7:0]  exp_function = 8'h00;
  logic [15:0] dead_limit = 16'd2;

  // Framing state of the predictor.
  mbrd_pkg::phase_t fr_phase = mbrd_pkg::PH_SOF;
  logic [6:0]  fr_index = 7'd0;
  logic [6:0]  fr_end = 7'd0;
  logic [6:0]  fr_count = 7'd0;
  logic [15:0] crc_acc = mbrd_pkg::CRC_INIT;
  logic [15:0] crc_rx = 16'h0000;
  logic [31:0] data_acc = 32'h0;
  logic [15:0] quiet_ticks = 16'h0000;

  bus_word_t      link_words[$];
  mbrd_pkg::res_t frames_due[$];

  int words_queued = 0;
  int words_taken = 0;
  int frames_good = 0;
  int frames_bad = 0;
  int mismatches = 0;
  int settings_used = 0;

  bus_word_t next_word;
  int tx_wait = 0;
  int tx_calm = 0;
  int rx_wait = 0;
  int rx_calm = 0;
  int hold_left = 0;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;
  int quiet_cycles = 0;
  mbrd_pkg::res_t due;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    logic fb;
    acc = c;
    for (int i = 0; i < 8; i++) begin
      fb = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ mbrd_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic frame_restart();
    fr_phase = mbrd_pkg::PH_SOF;
    fr_index = 7'd0;
    fr_end = 7'd0;
    fr_count = 7'd0;
    crc_acc = mbrd_pkg::CRC_INIT;
    crc_rx = 16'h0000;
    data_acc = 32'h0;
  endtask

  task automatic take_byte(input int idx, input logic [7:0] b);
    if (idx <= int'(fr_count) + 2) begin
      crc_acc = crc16_byte(crc_acc, b);
      data_acc = {data_acc[23:0], b};
    end else if (idx == int'(fr_count) + 3) begin
      crc_rx = {8'h00, b};
    end else begin
      crc_rx = crc_rx | {b, 8'h00};
    end
  endtask

  task automatic deframe_word(input logic is_tick, input logic [7:0] b);
    int idx;
    logic ok;
    mbrd_pkg::res_t r;
    if (is_tick) begin
      if (quiet_ticks != 16'hFFFF) begin
        quiet_ticks = quiet_ticks + 16'd1;
      end
    end else begin
      if (quiet_ticks >= dead_limit) begin
        frame_restart();
      end
      quiet_ticks = 16'h0000;
      idx = fr_index;
      case (fr_phase)
        mbrd_pkg::PH_DATA: begin
          take_byte(idx, b);
          if (idx >= fr_end) begin
            fr_end = fr_end + 7'd2;
            fr_phase = mbrd_pkg::PH_EOF;
          end
          fr_index = 7'(idx + 1);
        end
        mbrd_pkg::PH_EOF: begin
          take_byte(idx, b);
          if (idx < fr_end) begin
            fr_index = 7'(idx + 1);
          end else if (idx > fr_end) begin
            frame_restart();
          end else begin
            ok = (crc_rx == crc_acc) && (crc_acc != 16'h0000);
            r.frame_good = ok;
            r.crc_bad = !ok;
            r.payload_count = fr_count;
            r.value_short = (ok && fr_count == mbrd_pkg::COUNT_SHORT) ?
                            data_acc[15:0] : 16'h0000;
            r.value_long = (ok && fr_count == mbrd_pkg::COUNT_LONG) ? data_acc : 32'h0;
            frames_due.push_back(r);
            frame_restart();
          end
        end
        default: begin
          if (idx == 0 && b == exp_slave) begin
            crc_acc = crc16_byte(crc_acc, b);
            fr_index = 7'd1;
          end else if (idx == 1 && b == exp_function) begin
            crc_acc = crc16_byte(crc_acc, b);
            fr_index = 7'd2;
          end else if (idx == 2 && b < FRAME_COUNT_LIMIT) begin
            crc_acc = crc16_byte(crc_acc, b);
            fr_count = b[6:0];
            fr_end = 7'd2 + b[6:0];
            fr_phase = mbrd_pkg::PH_DATA;
            fr_index = mbrd_pkg::FIRST_DATA_INDEX;
          end else begin
            frame_restart();
          end
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    link_words.push_back('{1'b0, b});
    words_queued++;
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) begin
      link_words.push_back('{1'b1, 8'($urandom)});
      words_queued++;
    end
  endtask

  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] fn,
                             input logic [7:0] cnt, input frame_kind_t kind, input int upto);
    logic [7:0] msg[$];
    logic [15:0] crc;
    int inner;
    msg = '{addr, fn, cnt};
    for (int i = 0; i < int'(cnt); i++) begin
      msg.push_back(8'($urandom));
    end
    // For a zero CRC the last two data bytes carry the CRC of what precedes them.
    crc = mbrd_pkg::CRC_INIT;
    for (int i = 0; i < msg.size(); i++) begin
      if (kind == FK_ZERO_CRC && i == msg.size() - 2) begin
        msg[i] = crc[7:0];
        msg[i + 1] = crc[15:8];
      end
      crc = crc16_byte(crc, msg[i]);
    end
    if (kind == FK_BAD_CRC) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
    end
    msg.push_back(crc[7:0]);
    msg.push_back(crc[15:8]);
    inner = (dead_limit == 16'd0) ? 0 : ((dead_limit > 16'd7) ? 6 : int'(dead_limit) - 1);
    for (int i = 0; i < msg.size() && i < upto; i++) begin
      if (i > 0 && inner > 0 && $urandom_range(0, 7) == 0) begin
        queue_ticks($urandom_range(1, inner));
      end
      queue_byte(msg[i]);
    end
  endtask

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'(mbrd_pkg::COUNT_SHORT);
    if (r < 65) return 8'(mbrd_pkg::COUNT_LONG);
    if (r < 80) return 8'($urandom_range(0, 3));
    if (r < 99) return 8'($urandom_range(5, 16));
    return 8'(FRAME_COUNT_LIMIT - 1);
  endfunction

  task automatic queue_noise();
    noise_kind_t kind;
    kind = noise_kind_t'($urandom_range(0, 5));
    case (kind)
      NZ_BYTES: begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end
      NZ_TICKS: begin
        queue_ticks($urandom_range(1, 20));
      end
      NZ_BAD_SLAVE: begin
        queue_frame(exp_slave + 8'($urandom_range(1, 255)), exp_function, pick_count(),
                    FK_GOOD, FULL_FRAME);
      end
      NZ_BAD_FUNCTION: begin
        queue_frame(exp_slave, exp_function + 8'($urandom_range(1, 255)), pick_count(),
                    FK_GOOD, FULL_FRAME);
      end
      NZ_BIG_COUNT: begin
        queue_frame(exp_slave, exp_function, 8'($urandom_range(FRAME_COUNT_LIMIT, 255)),
                    FK_GOOD, 3 + $urandom_range(0, 4));
      end
      default: begin
        queue_frame(exp_slave, exp_function, pick_count(), FK_GOOD, $urandom_range(1, 8));
        if (dead_limit <= 16'd32) begin
          queue_ticks(int'(dead_limit));
        end
      end
    endcase
  endtask

  task automatic queue_gap_ticks();
    int r;
    r = $urandom_range(0, 99);
    if (r >= 85) begin
      if (dead_limit <= 16'd32) begin
        queue_ticks(int'(dead_limit) + $urandom_range(0, 2));
      end else begin
        queue_ticks($urandom_range(4, 12));
      end
    end else if (r >= 50) begin
      queue_ticks($urandom_range(1, 3));
    end
  endtask

  task automatic queue_random(input int target);
    int first;
    int r;
    logic [7:0] cnt;
    frame_kind_t kind;
    first = words_queued;
    while (words_queued - first < target) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        cnt = pick_count();
        r = $urandom_range(0, 99);
        if (r < 78) begin
          kind = FK_GOOD;
        end else if (r < 90 || cnt < 8'd2) begin
          kind = FK_BAD_CRC;
        end else begin
          kind = FK_ZERO_CRC;
        end
        queue_frame(exp_slave, exp_function, cnt, kind, FULL_FRAME);
      end else begin
        queue_noise();
      end
      queue_gap_ticks();
    end
  endtask

  task automatic queue_directed();
    queue_byte(8'hFF);
    queue_frame(exp_slave, exp_function, 8'd0, FK_GOOD, FULL_FRAME);
    queue_frame(exp_slave, exp_function, 8'd2, FK_BAD_CRC, FULL_FRAME);
    queue_byte(exp_slave);
    queue_byte(8'hFF);
    queue_byte(exp_slave);
    queue_byte(exp_function);
    queue_byte(8'(FRAME_COUNT_LIMIT));
    queue_byte(exp_slave);
    queue_byte(exp_function);
    queue_ticks(int'(dead_limit));
    queue_frame(exp_slave, exp_function, 8'd4, FK_GOOD, FULL_FRAME);
  endtask

  task automatic write_reg(input mbrd_pkg::reg_index_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_link(input logic [7:0] slave, input logic [7:0] fn,
                              input logic [15:0] dead);
    write_reg(mbrd_pkg::REG_EXPECTED_SLAVE, {8'($urandom), slave});
    write_reg(mbrd_pkg::REG_EXPECTED_FUNCTION, {8'($urandom), fn});
    write_reg(mbrd_pkg::REG_DEAD_TIME_LIMIT, dead);
    exp_slave = slave;
    exp_function = fn;
    dead_limit = dead;
    settings_used++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (link_words.size() != 0 || s_tvalid || frames_due.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (tx_wait > 0) begin
        tx_wait--;
        s_tvalid <= 1'b0;
      end else if (link_words.size() > 0) begin
        next_word = link_words.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= next_word.tick;
        s_tdata <= next_word.data;
        if (tx_calm > 0) begin
          tx_calm--;
        end else begin
          tx_wait = idle_len();
          if ($urandom_range(0, 99) == 0) begin
            tx_calm = $urandom_range(50, 200);
          end
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (rx_calm > 0) begin
        rx_calm--;
      end else begin
        rx_wait = idle_len();
        if ($urandom_range(0, 99) == 0) begin
          rx_calm = $urandom_range(50, 200);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        deframe_word(s_tuser[0], s_tdata);
        words_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (frames_due.size() == 0) begin
          report_mismatch($sformatf("result with no frame pending, tuser=%b tdata=%h",
                                    m_tuser, m_tdata));
        end else begin
          due = frames_due.pop_front();
          if (due.frame_good) begin
            frames_good++;
          end else begin
            frames_bad++;
          end
          if (m_tuser[0] !== due.frame_good) begin
            report_mismatch($sformatf("frame_good %b, want %b", m_tuser[0], due.frame_good));
          end
          if (m_tuser[1] !== due.crc_bad) begin
            report_mismatch($sformatf("crc_bad %b, want %b", m_tuser[1], due.crc_bad));
          end
          if (m_tdata[6:0] !== due.payload_count) begin
            report_mismatch($sformatf("payload_count %0d, want %0d",
                                      m_tdata[6:0], due.payload_count));
          end
          if (m_tdata[22:7] !== due.value_short) begin
            report_mismatch($sformatf("value_short %h, want %h",
                                      m_tdata[22:7], due.value_short));
          end
          if (m_tdata[54:23] !== due.value_long) begin
            report_mismatch($sformatf("value_long %h, want %h",
                                      m_tdata[54:23], due.value_long));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no input word accepted for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    queue_directed();
    queue_random(300);
    wait_idle();

    program_link(8'hFF, 8'hFF, 16'hFFFF);
    queue_frame(exp_slave, exp_function, 8'(FRAME_COUNT_LIMIT - 1), FK_GOOD, FULL_FRAME);
    queue_random(250);
    // A silence well below the limit leaves a partial header standing.
    queue_byte(exp_slave);
    queue_byte(exp_function);
    queue_ticks(40);
    queue_frame(exp_slave, exp_function, 8'(mbrd_pkg::COUNT_SHORT), FK_GOOD, FULL_FRAME);
    wait_idle();

    program_link(8'($urandom), 8'h03, 16'h0000);
    queue_random(120);
    wait_idle();

    program_link(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)), 16'd1);
    queue_random(350);
    wait_idle();

    program_link(8'($urandom), 8'($urandom), 16'($urandom_range(3, 10)));
    queue_random(400);
    hold_armed = 1'b1;
    wait_idle();

    program_link(8'($urandom), 8'($urandom), 16'd2);
    queue_random(200);
    wait_idle();

    $display("Checked %0d frame results (%0d good, %0d failing the CRC) from %0d input words,",
             frames_good + frames_bad, frames_good, frames_bad, words_taken);
    $display("over %0d link settings, with one long output stall of %0d cycles.",
             settings_used + 1, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mbrd_pkg.sv
hdl/mbrd_engine.sv
hdl/modbus_rtu_response_deframer.sv
tb/tb_modbus_rtu_response_deframer.sv
